### sv/htp_pkg.sv
// Shared types, codes and constants of the heading turn controller.
package htp_pkg;

   localparam int AngleW  = 24;
   localparam int ErrW    = 25;
   localparam int IntW    = 26;
   localparam int DiffW   = 26;
   localparam int GainW   = 16;
   localparam int ScaleW  = 13;
   localparam int Tmag9W  = 27;
   localparam int E10W    = 29;
   localparam int MulAW   = 27;
   localparam int MulBW   = 17;
   localparam int ProdW   = 44;
   localparam int PaccW   = 58;
   localparam int PmagW   = 57;
   localparam int UmW     = 33;
   localparam int SpeedW  = 19;
   localparam int SatW    = 18;
   localparam int StatusW = 2;
   localparam int StallW  = 5;
   localparam int IdxW    = 3;
   localparam int SplitW  = 22;
   localparam int RoundSh = 24;

   // Register indexes on the configuration port.
   localparam logic [IdxW-1:0] CSR_TARGET_ANGLE = 3'd0;
   localparam logic [IdxW-1:0] CSR_GAIN_P       = 3'd1;
   localparam logic [IdxW-1:0] CSR_GAIN_I       = 3'd2;
   localparam logic [IdxW-1:0] CSR_GAIN_D       = 3'd3;
   localparam logic [IdxW-1:0] CSR_OUTPUT_SCALE = 3'd4;

   localparam logic [GainW-1:0]  GAIN_P_RESET       = 16'd11469;
   localparam logic [GainW-1:0]  GAIN_I_RESET       = 16'd143;
   localparam logic [GainW-1:0]  GAIN_D_RESET       = 16'd20480;
   localparam logic [ScaleW-1:0] OUTPUT_SCALE_RESET = 13'd4096;

   // Result status codes.
   localparam logic [StatusW-1:0] STATUS_DRIVING = 2'd0;
   localparam logic [StatusW-1:0] STATUS_SETTLED = 2'd1;
   localparam logic [StatusW-1:0] STATUS_STALLED = 2'd2;
   localparam logic [StatusW-1:0] STATUS_IDLE    = 2'd3;

   localparam logic [ErrW-1:0]   SETTLE_BAND    = 25'd512;
   localparam logic [AngleW-1:0] STILL_BAND     = 24'd77;
   localparam logic [StallW-1:0] STALL_LIMIT    = 5'd20;
   localparam logic [StallW-1:0] STALL_MAX      = 5'd31;
   localparam logic [IntW-1:0]   INTEGRAL_LIMIT = 26'd256000;
   localparam logic [UmW-1:0]    SPEED_LIMIT    = 33'd153600;
   localparam logic [PmagW-1:0]  ROUND_HALF     = 57'h800000;

   typedef struct packed {
      logic signed [AngleW-1:0] target_angle;
      logic [GainW-1:0]         gain_p;
      logic [GainW-1:0]         gain_i;
      logic [GainW-1:0]         gain_d;
      logic [ScaleW-1:0]        output_scale;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_ERR,
      ST_MAG,
      ST_DECIDE,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_SUM,
      ST_SCL_LO,
      ST_SCL_HI,
      ST_SCL_ADD,
      ST_PMAG,
      ST_ROUND,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      OC_START,
      OC_IDLE,
      OC_SETTLED,
      OC_STALLED,
      OC_DRIVE
   } outcome_type;

   typedef enum logic [2:0] {
      MS_P,
      MS_I,
      MS_D,
      MS_LO,
      MS_HI
   } mul_sel_type;

   typedef struct packed {
      logic        load_in;
      logic        step_diff;
      logic        step_err;
      logic        step_mag;
      logic        decide;
      outcome_type outcome;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        acc_load;
      logic        acc_add;
      logic        pacc_load;
      logic        pacc_add;
      logic        step_pmag;
      logic        step_round;
      logic        load_rsp;
   } cmd_type;

   typedef struct packed {
      logic start;
      logic active;
      logic settled;
      logic stalled;
   } stat_type;

endpackage

### sv/htp_csr.sv
// Configuration register file of the heading turn controller.
module htp_csr (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [htp_pkg::IdxW-1:0]                csr_index,
   input  logic [htp_pkg::AngleW-1:0]              csr_data,
   output htp_pkg::cfg_type                        cfg
);
   import htp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TARGET_ANGLE: cfg_in.target_angle = $signed(csr_data);
            CSR_GAIN_P:       cfg_in.gain_p       = csr_data[GainW-1:0];
            CSR_GAIN_I:       cfg_in.gain_i       = csr_data[GainW-1:0];
            CSR_GAIN_D:       cfg_in.gain_d       = csr_data[GainW-1:0];
            CSR_OUTPUT_SCALE: cfg_in.output_scale = csr_data[ScaleW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_angle <= '0;
         cfg_ff.gain_p       <= GAIN_P_RESET;
         cfg_ff.gain_i       <= GAIN_I_RESET;
         cfg_ff.gain_d       <= GAIN_D_RESET;
         cfg_ff.output_scale <= OUTPUT_SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/htp_ctrl.sv
// Sequencing state machine and result handshake of the heading turn controller.
module htp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  htp_pkg::stat_type stat,
   output htp_pkg::cmd_type  cmd
);
   import htp_pkg::*;

   state_type   state_ff;
   state_type   state_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic        can_load;
   outcome_type outcome;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign can_load  = !rsp_valid_ff || rsp_ready;

   // Start beats everything, then the idle case, then settling, then stalling.
   always_comb begin
      if (stat.start) begin
         outcome = OC_START;
      end else if (!stat.active) begin
         outcome = OC_IDLE;
      end else if (stat.settled) begin
         outcome = OC_SETTLED;
      end else if (stat.stalled) begin
         outcome = OC_STALLED;
      end else begin
         outcome = OC_DRIVE;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_DIFF;
         ST_DIFF:    state_in = ST_ERR;
         ST_ERR:     state_in = ST_MAG;
         ST_MAG:     state_in = ST_DECIDE;
         ST_DECIDE:  state_in = (outcome == OC_DRIVE) ? ST_MUL_P : ST_OUT;
         ST_MUL_P:   state_in = ST_MUL_I;
         ST_MUL_I:   state_in = ST_MUL_D;
         ST_MUL_D:   state_in = ST_SUM;
         ST_SUM:     state_in = ST_SCL_LO;
         ST_SCL_LO:  state_in = ST_SCL_HI;
         ST_SCL_HI:  state_in = ST_SCL_ADD;
         ST_SCL_ADD: state_in = ST_PMAG;
         ST_PMAG:    state_in = ST_ROUND;
         ST_ROUND:   state_in = ST_OUT;
         ST_OUT:     if (can_load) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.outcome = OC_IDLE;
      cmd.mul_sel = MS_P;
      case (state_ff)
         ST_IDLE:    cmd.load_in   = req_valid;
         ST_DIFF:    cmd.step_diff = 1'b1;
         ST_ERR:     cmd.step_err  = 1'b1;
         ST_MAG:     cmd.step_mag  = 1'b1;
         ST_DECIDE: begin
            cmd.decide  = 1'b1;
            cmd.outcome = outcome;
         end
         ST_MUL_P: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MS_P;
         end
         ST_MUL_I: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MS_I;
            cmd.acc_load = 1'b1;
         end
         ST_MUL_D: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MS_D;
            cmd.acc_add = 1'b1;
         end
         ST_SUM:     cmd.acc_add = 1'b1;
         ST_SCL_LO: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MS_LO;
         end
         ST_SCL_HI: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MS_HI;
            cmd.pacc_load = 1'b1;
         end
         ST_SCL_ADD: cmd.pacc_add   = 1'b1;
         ST_PMAG:    cmd.step_pmag  = 1'b1;
         ST_ROUND:   cmd.step_round = 1'b1;
         ST_OUT:     cmd.load_rsp   = can_load;
         default: ;
      endcase
   end

   always_comb begin
      if (state_ff == ST_OUT && can_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### sv/htp_dp.sv
// Datapath of the heading turn controller: move state, PID arithmetic, output register.
module htp_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  htp_pkg::cmd_type                    cmd,
   input  htp_pkg::cfg_type                    cfg,
   input  logic                                req_start_req,
   input  logic signed [htp_pkg::AngleW-1:0]   req_heading,
   output htp_pkg::stat_type                   stat,
   output logic signed [htp_pkg::SpeedW-1:0]   rsp_speed,
   output logic [htp_pkg::StatusW-1:0]         rsp_status
);
   import htp_pkg::*;

   // Captured item and intermediate values.
   logic                     start_ff, start_in;
   logic signed [AngleW-1:0] heading_ff, heading_in;
   logic signed [AngleW-1:0] turned_ff, turned_in;
   logic signed [AngleW-1:0] delta_ff, delta_in;
   logic signed [ErrW-1:0]   err_ff, err_in;
   logic [AngleW-1:0]        dmag_ff, dmag_in;
   logic [Tmag9W-1:0]        tmag9_ff, tmag9_in;
   logic [ErrW-1:0]          emag_ff, emag_in;
   logic                     imag_ok_ff, imag_ok_in;
   logic signed [DiffW-1:0]  diff_ff, diff_in;
   outcome_type              outcome_ff, outcome_in;

   // Move state.
   logic                     active_ff, active_in;
   logic signed [AngleW-1:0] ref_ff, ref_in;
   logic signed [AngleW-1:0] prev_h_ff, prev_h_in;
   logic signed [IntW-1:0]   integral_ff, integral_in;
   logic signed [ErrW-1:0]   prev_err_ff, prev_err_in;
   logic [StallW-1:0]        stall_ff, stall_in;

   // Multiply and accumulate.
   logic signed [MulAW-1:0]  mul_a;
   logic signed [MulBW-1:0]  mul_b;
   logic signed [ProdW-1:0]  prod_ff, prod_in;
   logic signed [ProdW-1:0]  acc_ff, acc_in;
   logic signed [PaccW-1:0]  pacc_ff, pacc_in;
   logic                     psign_ff, psign_in;
   logic [PmagW-1:0]         pmag_ff, pmag_in;
   logic [UmW-1:0]           um_ff, um_in;
   logic signed [SpeedW-1:0] rsp_speed_ff, rsp_speed_in;
   logic [StatusW-1:0]       rsp_status_ff, rsp_status_in;

   logic [AngleW-1:0]        tmag;
   logic [IntW-1:0]          imag;
   logic [E10W-1:0]          e10;
   logic                     still;
   logic [StallW-1:0]        stall_next;
   logic                     gate;
   logic signed [IntW-1:0]   err_ext;
   logic [SatW-1:0]          sat_mag;
   logic signed [SpeedW-1:0] speed_drive;

   assign rsp_speed  = rsp_speed_ff;
   assign rsp_status = rsp_status_ff;

   // Angle differences wrap at 24 bits.
   assign turned_in = heading_ff - ref_ff;
   assign delta_in  = heading_ff - prev_h_ff;
   assign err_in    = ErrW'(cfg.target_angle) - ErrW'(turned_ff);
   assign dmag_in   = delta_ff[AngleW-1] ? AngleW'(-delta_ff) : delta_ff;
   assign tmag      = cfg.target_angle[AngleW-1] ? AngleW'(-cfg.target_angle)
                                                 : cfg.target_angle;
   assign tmag9_in  = {tmag, 3'b000} + Tmag9W'(tmag);
   assign emag_in   = err_ff[ErrW-1] ? ErrW'(-err_ff) : err_ff;
   assign imag      = integral_ff[IntW-1] ? IntW'(-integral_ff) : integral_ff;
   assign imag_ok_in = (imag < INTEGRAL_LIMIT);

   assign still      = (dmag_ff < STILL_BAND);
   assign stall_next = !still ? '0 : ((stall_ff == STALL_MAX) ? stall_ff
                                                               : stall_ff + 5'd1);
   assign e10        = E10W'({emag_ff, 3'b000}) + E10W'({emag_ff, 1'b0});
   assign gate       = (e10 < E10W'(tmag9_ff)) && imag_ok_ff;
   assign err_ext    = IntW'(err_ff);
   assign diff_in    = err_ext - IntW'(prev_err_ff);

   assign stat.start   = start_ff;
   assign stat.active  = active_ff;
   assign stat.settled = (emag_ff <= SETTLE_BAND);
   assign stat.stalled = (stall_next > STALL_LIMIT);

   assign start_in   = req_start_req;
   assign heading_in = req_heading;
   assign outcome_in = cmd.outcome;

   always_comb begin
      active_in   = active_ff;
      ref_in      = ref_ff;
      prev_h_in   = prev_h_ff;
      integral_in = integral_ff;
      prev_err_in = prev_err_ff;
      stall_in    = stall_ff;
      if (cmd.decide) begin
         case (cmd.outcome)
            OC_START: begin
               active_in   = 1'b1;
               ref_in      = heading_ff;
               prev_h_in   = heading_ff;
               integral_in = '0;
               prev_err_in = ErrW'(cfg.target_angle);
               stall_in    = '0;
            end
            OC_SETTLED: active_in = 1'b0;
            OC_STALLED: begin
               active_in = 1'b0;
               prev_h_in = heading_ff;
               stall_in  = stall_next;
            end
            OC_DRIVE: begin
               prev_h_in   = heading_ff;
               stall_in    = stall_next;
               prev_err_in = err_ff;
               if (gate) integral_in = integral_ff + err_ext;
            end
            default: ;
         endcase
      end
   end

   // One shared 27 x 17 signed multiplier for the gains and the output scale.
   always_comb begin
      case (cmd.mul_sel)
         MS_P: begin
            mul_a = MulAW'(err_ff);
            mul_b = $signed({1'b0, cfg.gain_p});
         end
         MS_I: begin
            mul_a = MulAW'(integral_ff);
            mul_b = $signed({1'b0, cfg.gain_i});
         end
         MS_D: begin
            mul_a = MulAW'(diff_ff);
            mul_b = $signed({1'b0, cfg.gain_d});
         end
         MS_LO: begin
            mul_a = $signed({{(MulAW-SplitW){1'b0}}, acc_ff[SplitW-1:0]});
            mul_b = $signed({{(MulBW-ScaleW){1'b0}}, cfg.output_scale});
         end
         MS_HI: begin
            mul_a = $signed({{(MulAW-SplitW){acc_ff[ProdW-1]}}, acc_ff[ProdW-1:SplitW]});
            mul_b = $signed({{(MulBW-ScaleW){1'b0}}, cfg.output_scale});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = ProdW'(mul_a) * ProdW'(mul_b);

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_load) begin
         acc_in = prod_ff;
      end else if (cmd.acc_add) begin
         acc_in = acc_ff + prod_ff;
      end
   end

   // The high partial product is below 2^35 in magnitude, so its low 36 bits carry it.
   always_comb begin
      pacc_in = pacc_ff;
      if (cmd.pacc_load) begin
         pacc_in = PaccW'(prod_ff);
      end else if (cmd.pacc_add) begin
         pacc_in = pacc_ff + $signed({prod_ff[PaccW-SplitW-1:0], {SplitW{1'b0}}});
      end
   end

   assign psign_in = pacc_ff[PaccW-1];
   assign pmag_in  = pacc_ff[PaccW-1] ? PmagW'(-pacc_ff) : pacc_ff[PmagW-1:0];
   assign um_in    = UmW'((pmag_ff + ROUND_HALF) >> RoundSh);

   assign sat_mag     = (um_ff > SPEED_LIMIT) ? SPEED_LIMIT[SatW-1:0] : um_ff[SatW-1:0];
   assign speed_drive = psign_ff ? -$signed({1'b0, sat_mag}) : $signed({1'b0, sat_mag});

   always_comb begin
      case (outcome_ff)
         OC_START:   rsp_status_in = STATUS_DRIVING;
         OC_IDLE:    rsp_status_in = STATUS_IDLE;
         OC_SETTLED: rsp_status_in = STATUS_SETTLED;
         OC_STALLED: rsp_status_in = STATUS_STALLED;
         OC_DRIVE:   rsp_status_in = STATUS_DRIVING;
         default:    rsp_status_in = STATUS_IDLE;
      endcase
      rsp_speed_in = (outcome_ff == OC_DRIVE) ? speed_drive : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         ref_ff      <= '0;
         prev_h_ff   <= '0;
         integral_ff <= '0;
         prev_err_ff <= '0;
         stall_ff    <= '0;
      end else begin
         active_ff   <= active_in;
         ref_ff      <= ref_in;
         prev_h_ff   <= prev_h_in;
         integral_ff <= integral_in;
         prev_err_ff <= prev_err_in;
         stall_ff    <= stall_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         start_ff   <= start_in;
         heading_ff <= heading_in;
      end
      if (cmd.step_diff) begin
         turned_ff <= turned_in;
         delta_ff  <= delta_in;
      end
      if (cmd.step_err) begin
         err_ff   <= err_in;
         dmag_ff  <= dmag_in;
         tmag9_ff <= tmag9_in;
      end
      if (cmd.step_mag) begin
         emag_ff    <= emag_in;
         imag_ok_ff <= imag_ok_in;
      end
      if (cmd.decide) begin
         diff_ff    <= diff_in;
         outcome_ff <= outcome_in;
      end
      if (cmd.mul_en) prod_ff <= prod_in;
      acc_ff  <= acc_in;
      pacc_ff <= pacc_in;
      if (cmd.step_pmag) begin
         psign_ff <= psign_in;
         pmag_ff  <= pmag_in;
      end
      if (cmd.step_round) um_ff <= um_in;
      if (cmd.load_rsp) begin
         rsp_speed_ff  <= rsp_speed_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

endmodule

### sv/heading_turn_pid_top.sv
// Top level of the heading turn controller: configuration registers, sequencer, datapath.
//
// This block closes the loop for a turn in place. It takes one heading item per sensor tick
// and returns one result item for each: a left motor speed in 1/256 rpm (the right motors
// take the negated value) and a status of driving, settled, stalled or idle. An item with
// start_req set latches its heading as the reference and clears the move state. Items are
// handled one at a time. A start item, an item while no move is active, and an item that
// ends the move pass through these steps from acceptance until the block is ready again:
// capture, three steps to form and compare the turned angle, error and step size, a
// decision, and a load of the output register. A driving item also passes the PID terms
// and the output scale through a single shared 27 x 17 multiplier, one product per
// cycle, between the decision and the rounding and saturation. The result sits in an output
// register, so the next item is accepted while an earlier result still waits to be taken;
// the block holds its last step only if a new result is ready before the old one is taken.
// Configuration writes are always accepted and should be made while the block is idle.
module heading_turn_pid_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_start_req,
   input  logic signed [htp_pkg::AngleW-1:0]   req_heading,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [htp_pkg::SpeedW-1:0]   rsp_speed,
   output logic [htp_pkg::StatusW-1:0]         rsp_status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [htp_pkg::IdxW-1:0]            csr_index,
   input  logic [htp_pkg::AngleW-1:0]          csr_data
);
   import htp_pkg::*;

   // Register values, the sequencer's step commands and the datapath's decision flags.
   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;

   htp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // The sequencer walks each item through the datapath and owns both handshakes.
   htp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath keeps the move state and drives the result payload.
   htp_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cfg           (cfg),
      .req_start_req (req_start_req),
      .req_heading   (req_heading),
      .stat          (stat),
      .rsp_speed     (rsp_speed),
      .rsp_status    (rsp_status)
   );

endmodule
